// ===== rtl/core/rlm_pkg.sv =====
package rlm_pkg;

    // Converter sample width and derived datapath widths
    localparam int SAMPLE_BITS   = 12;
    localparam int DC_BITS       = 12;
    localparam int MAG_BITS      = (SAMPLE_BITS > DC_BITS) ? SAMPLE_BITS : DC_BITS;
    localparam int SQ_BITS       = 2 * MAG_BITS;
    localparam int SUM_BITS      = 32;
    localparam int CNT_BITS      = 8;
    localparam int BS_BITS       = 8;
    localparam int FRAC_BITS     = 16;
    localparam int Q_BITS        = SUM_BITS + FRAC_BITS;
    localparam int THR10_BITS    = Q_BITS + 4;
    localparam int STEP_BITS     = 6;
    localparam int DEC_BITS      = 4;
    localparam int FINE_BITS     = 4;
    localparam int LVAL_BITS     = 80;
    localparam int CONST_BITS    = 63;
    localparam int LEVEL_BITS    = 7;
    localparam int S_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS  = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 12;

    // Search limits: q is scaled by 10^(SCALE_TOP - decade) before the fine compare
    localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(Q_BITS - 1);
    localparam logic [STEP_BITS-1:0] SCALE_TOP = STEP_BITS'(18);
    localparam logic [FINE_BITS-1:0] FINE_TOP  = FINE_BITS'(9);

    // Register indexes and reset values
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_SIZE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DC_OFFSET  = 1'b1;
    localparam logic [BS_BITS-1:0]      BLOCK_SIZE_RST = BS_BITS'(100);
    localparam logic [DC_BITS-1:0]      DC_OFFSET_RST  = DC_BITS'(2048);

    // Controller states
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQUARE = 8'b0000_0010,
        ST_ACCUM  = 8'b0000_0100,
        ST_DIV    = 8'b0000_1000,
        ST_DECADE = 8'b0001_0000,
        ST_SCALE  = 8'b0010_0000,
        ST_FINE   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_sample;
        logic square;
        logic accum;
        logic div_step;
        logic dec_step;
        logic scale_init;
        logic scale_step;
        logic fine_step;
        logic load_out;
    } rlm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic block_done;
        logic div_last;
        logic below;
        logic dec_more;
        logic scale_done;
        logic fine_more;
        logic out_free;
    } rlm_stat_t;

    // 10^(b/10) scaled by 10^18, b = 0..9
    function automatic logic [CONST_BITS-1:0] fine_const(input logic [FINE_BITS-1:0] b);
        logic [CONST_BITS-1:0] r;
        case (b)
            4'd0:    r = 63'd1000000000000000000;
            4'd1:    r = 63'd1258925411794167210;
            4'd2:    r = 63'd1584893192461113485;
            4'd3:    r = 63'd1995262314968879601;
            4'd4:    r = 63'd2511886431509580111;
            4'd5:    r = 63'd3162277660168379332;
            4'd6:    r = 63'd3981071705534972508;
            4'd7:    r = 63'd5011872336272722851;
            4'd8:    r = 63'd6309573444801932494;
            4'd9:    r = 63'd7943282347242815021;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/rms_level_db_meter_unit.sv =====
// Channel  Ports                              Payload (lowest bit up)
// input    s_tvalid/s_tready/s_tdata          sample[11:0], zero pad
// result   m_tvalid/m_tready/m_tdata/m_tuser  tdata: level_db[6:0], zero pad; tuser: below_floor
// config   cfg_we/cfg_index/cfg_wdata         0: block_size[7:0], 1: dc_offset[11:0]
//
// A sample is accepted, squared and accumulated in turn; s_tready is high only
// while the controller is idle. The last sample of a block then runs the
// bit-serial divide, the decade search and times-ten scaling, and the fine
// compare, and loads the output; when the mean is below the floor, the scaling
// and the fine compare are skipped.
// Reset (aresetn, synchronous) clears the sum, the count and the output valid.
// A stalled result waits in the output register; the block keeps taking
// samples until the next block result needs that register.
module rms_level_db_meter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rlm_pkg::S_TDATA_BITS-1:0]     s_tdata,   // sample, zero pad
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rlm_pkg::M_TDATA_BITS-1:0]     m_tdata,   // level_db, zero pad
    output logic                                 m_tuser,   // below_floor
    input  logic                                 cfg_we,
    input  logic [rlm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [rlm_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    logic [rlm_pkg::BS_BITS-1:0]    block_size_reg;
    logic [rlm_pkg::DC_BITS-1:0]    dc_offset_reg;
    rlm_pkg::rlm_cmd_t              cmd;
    rlm_pkg::rlm_stat_t             stat;
    logic [rlm_pkg::LEVEL_BITS-1:0] level_db;
    logic                           below_floor;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= rlm_pkg::BLOCK_SIZE_RST;
            dc_offset_reg  <= rlm_pkg::DC_OFFSET_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rlm_pkg::REG_BLOCK_SIZE: block_size_reg <= cfg_wdata[rlm_pkg::BS_BITS-1:0];
                rlm_pkg::REG_DC_OFFSET:  dc_offset_reg  <= cfg_wdata[rlm_pkg::DC_BITS-1:0];
            endcase
        end
    end

    rlm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rlm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample      (s_tdata[rlm_pkg::SAMPLE_BITS-1:0]),
        .block_size  (block_size_reg),
        .dc_offset   (dc_offset_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .level_db    (level_db),
        .below_floor (below_floor)
    );

    assign m_tdata = rlm_pkg::M_TDATA_BITS'(level_db);
    assign m_tuser = below_floor;

endmodule

// ===== rtl/core/rlm_ctrl.sv =====
module rlm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rlm_pkg::rlm_stat_t stat,
    output rlm_pkg::rlm_cmd_t  cmd
);

    rlm_pkg::state_t state_reg;
    rlm_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rlm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == rlm_pkg::ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            rlm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = rlm_pkg::ST_SQUARE;
                end
            end
            rlm_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = rlm_pkg::ST_ACCUM;
            end
            rlm_pkg::ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = stat.block_done ? rlm_pkg::ST_DIV : rlm_pkg::ST_IDLE;
            end
            rlm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = rlm_pkg::ST_DECADE;
                end
            end
            rlm_pkg::ST_DECADE: begin
                if (stat.dec_more) begin
                    cmd.dec_step = 1'b1;
                end else if (stat.below) begin
                    state_next = rlm_pkg::ST_OUT;
                end else begin
                    cmd.scale_init = 1'b1;
                    state_next     = rlm_pkg::ST_SCALE;
                end
            end
            rlm_pkg::ST_SCALE: begin
                if (stat.scale_done) begin
                    state_next = rlm_pkg::ST_FINE;
                end else begin
                    cmd.scale_step = 1'b1;
                end
            end
            rlm_pkg::ST_FINE: begin
                if (stat.fine_more) begin
                    cmd.fine_step = 1'b1;
                end else begin
                    state_next = rlm_pkg::ST_OUT;
                end
            end
            rlm_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = rlm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rlm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/rlm_dp.sv =====
module rlm_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [rlm_pkg::SAMPLE_BITS-1:0]     sample,
    input  logic [rlm_pkg::BS_BITS-1:0]         block_size,
    input  logic [rlm_pkg::DC_BITS-1:0]         dc_offset,
    input  rlm_pkg::rlm_cmd_t                   cmd,
    output rlm_pkg::rlm_stat_t                  stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rlm_pkg::LEVEL_BITS-1:0]      level_db,
    output logic                                below_floor
);

    logic [rlm_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [rlm_pkg::SQ_BITS-1:0]     sq_reg;
    logic [rlm_pkg::SUM_BITS-1:0]    sum_reg;
    logic [rlm_pkg::CNT_BITS-1:0]    cnt_reg;
    logic [rlm_pkg::Q_BITS-1:0]      quo_reg;
    logic [rlm_pkg::BS_BITS-1:0]     rem_reg;
    logic [rlm_pkg::STEP_BITS-1:0]   step_reg;
    logic [rlm_pkg::Q_BITS-1:0]      thr_reg;
    logic [rlm_pkg::DEC_BITS-1:0]    dec_reg;
    logic [rlm_pkg::FINE_BITS-1:0]   fine_reg;
    logic [rlm_pkg::LVAL_BITS-1:0]   lval_reg;
    logic [rlm_pkg::LEVEL_BITS-1:0]  level_reg;
    logic                            flag_reg;
    logic                            mvalid_reg;

    logic [rlm_pkg::MAG_BITS-1:0]    samp_ext;
    logic [rlm_pkg::MAG_BITS-1:0]    dc_ext;
    logic [rlm_pkg::MAG_BITS-1:0]    mag;
    logic [rlm_pkg::SUM_BITS:0]      sum_wide;
    logic [rlm_pkg::SUM_BITS-1:0]    sum_sat;
    logic [rlm_pkg::CNT_BITS-1:0]    cnt_inc;
    logic [rlm_pkg::BS_BITS-1:0]     n_eff;
    logic [rlm_pkg::BS_BITS:0]       rem_sh;
    logic                            rem_ge;
    logic [rlm_pkg::THR10_BITS-1:0]  thr10;
    logic [rlm_pkg::LVAL_BITS-1:0]   lval10;
    logic [rlm_pkg::FINE_BITS-1:0]   fine_inc;
    logic [rlm_pkg::LVAL_BITS-1:0]   fine_thr;
    logic [rlm_pkg::STEP_BITS-1:0]   scale_cnt;
    logic [rlm_pkg::LEVEL_BITS-1:0]  level_calc;

    // Absolute difference from the DC offset
    assign samp_ext = rlm_pkg::MAG_BITS'(sample_reg);
    assign dc_ext   = rlm_pkg::MAG_BITS'(dc_offset);
    assign mag      = (samp_ext >= dc_ext) ? (samp_ext - dc_ext) : (dc_ext - samp_ext);

    // Saturating accumulate and block count
    assign sum_wide = (rlm_pkg::SUM_BITS + 1)'(sum_reg) + (rlm_pkg::SUM_BITS + 1)'(sq_reg);
    assign sum_sat  = sum_wide[rlm_pkg::SUM_BITS] ? '1 : sum_wide[rlm_pkg::SUM_BITS-1:0];
    assign cnt_inc  = cnt_reg + 1'b1;
    assign n_eff    = (block_size == '0) ? rlm_pkg::BS_BITS'(1) : block_size;

    // Restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[rlm_pkg::Q_BITS-1]};
    assign rem_ge = (rem_sh >= (rlm_pkg::BS_BITS + 1)'(n_eff));

    // Times-ten by shift and add
    assign thr10  = (rlm_pkg::THR10_BITS'(thr_reg) << 3) + (rlm_pkg::THR10_BITS'(thr_reg) << 1);
    assign lval10 = (lval_reg << 3) + (lval_reg << 1);

    // Fine threshold for the next tenth of a decade, aligned to q's fraction bits
    assign fine_inc  = fine_reg + 1'b1;
    assign fine_thr  = rlm_pkg::LVAL_BITS'(rlm_pkg::fine_const(fine_inc)) << rlm_pkg::FRAC_BITS;
    assign scale_cnt = rlm_pkg::SCALE_TOP - rlm_pkg::STEP_BITS'(dec_reg);

    assign level_calc = (rlm_pkg::LEVEL_BITS'(dec_reg) << 3)
                      + (rlm_pkg::LEVEL_BITS'(dec_reg) << 1)
                      + rlm_pkg::LEVEL_BITS'(fine_reg);

    // Status toward the controller
    always_comb begin
        stat.block_done = (cnt_inc >= n_eff);
        stat.div_last   = (step_reg == rlm_pkg::DIV_LAST);
        stat.below      = (quo_reg[rlm_pkg::Q_BITS-1:rlm_pkg::FRAC_BITS] == '0);
        stat.dec_more   = (rlm_pkg::THR10_BITS'(quo_reg) >= thr10);
        stat.scale_done = (step_reg == scale_cnt);
        stat.fine_more  = (fine_reg != rlm_pkg::FINE_TOP) && (lval_reg >= fine_thr);
        stat.out_free   = !mvalid_reg || m_tready;
    end

    // Accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.accum) begin
            if (stat.block_done) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_sat;
                cnt_reg <= cnt_inc;
            end
        end
    end

    // Sample, square and level search payload
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= sample;
        end
        if (cmd.square) begin
            sq_reg <= rlm_pkg::SQ_BITS'(mag) * rlm_pkg::SQ_BITS'(mag);
        end
        if (cmd.accum) begin
            quo_reg  <= {sum_sat, {rlm_pkg::FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            step_reg <= '0;
            thr_reg  <= rlm_pkg::Q_BITS'(1) << rlm_pkg::FRAC_BITS;
            dec_reg  <= '0;
            fine_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg  <= {quo_reg[rlm_pkg::Q_BITS-2:0], rem_ge};
            rem_reg  <= rem_ge ? rlm_pkg::BS_BITS'(rem_sh - (rlm_pkg::BS_BITS + 1)'(n_eff))
                               : rem_sh[rlm_pkg::BS_BITS-1:0];
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.dec_step) begin
            thr_reg <= rlm_pkg::Q_BITS'(thr10);
            dec_reg <= dec_reg + 1'b1;
        end
        if (cmd.scale_init) begin
            lval_reg <= rlm_pkg::LVAL_BITS'(quo_reg);
            step_reg <= '0;
        end
        if (cmd.scale_step) begin
            lval_reg <= lval10;
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.fine_step) begin
            fine_reg <= fine_inc;
        end
        if (cmd.load_out) begin
            level_reg <= level_calc;
            flag_reg  <= stat.below;
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid    = mvalid_reg;
    assign level_db    = level_reg;
    assign below_floor = flag_reg;

endmodule

// ===== test/testbench.sv =====
module testbench;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int SAMPLE_MAX    = (1 << rlm_pkg::SAMPLE_BITS) - 1;
    localparam int RANDOM_ITEMS  = 255;

    // Expected result: below_floor from m_tuser, level_db from m_tdata
    typedef struct packed {
        logic                           below;
        logic [rlm_pkg::LEVEL_BITS-1:0] level;
    } level_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [rlm_pkg::S_TDATA_BITS-1:0]  s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [rlm_pkg::M_TDATA_BITS-1:0]  m_tdata;
    logic                              m_tuser;
    logic                              cfg_we    = 1'b0;
    logic [rlm_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [rlm_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // Shadow of the meter: registers and accumulator
    logic [rlm_pkg::BS_BITS-1:0]  bs_now    = rlm_pkg::BLOCK_SIZE_RST;
    logic [rlm_pkg::DC_BITS-1:0]  dc_now    = rlm_pkg::DC_OFFSET_RST;
    logic [rlm_pkg::SUM_BITS-1:0] sum_now   = '0;
    logic [rlm_pkg::CNT_BITS-1:0] count_now = '0;

    level_t level_queue[$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    int     hold_left      = 0;
    int     amp_bits       = 11;
    bit     tx_steady      = 1'b0;
    bit     rx_steady      = 1'b0;

    rms_level_db_meter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Largest d with q^10 >= 2^160 * 10^d, i.e. floor(10*log10(q / 2^16))
    function automatic logic [rlm_pkg::LEVEL_BITS-1:0] db_level(
        input logic [rlm_pkg::Q_BITS-1:0] q);
        logic [511:0] pw;
        logic [511:0] thr;
        int           d;
        pw = 512'd1;
        for (int k = 0; k < 10; k++) pw = pw * 512'(q);
        thr = 512'd1 << 160;
        d = 0;
        while (d < 127) begin
            thr = thr * 512'd10;
            if (thr > pw) break;
            d++;
        end
        return d[rlm_pkg::LEVEL_BITS-1:0];
    endfunction

    // Accumulate one accepted sample; queue the level when the block closes
    function automatic void accumulate_sample(input logic [rlm_pkg::S_TDATA_BITS-1:0] data);
        int                           diff;
        logic [rlm_pkg::SUM_BITS:0]   total;
        logic [rlm_pkg::BS_BITS-1:0]  n;
        logic [rlm_pkg::Q_BITS-1:0]   q;
        level_t                       r;
        diff = int'(data[rlm_pkg::SAMPLE_BITS-1:0]) - int'(dc_now);
        total = {1'b0, sum_now} + (rlm_pkg::SUM_BITS + 1)'(diff * diff);
        sum_now = total[rlm_pkg::SUM_BITS] ? '1 : total[rlm_pkg::SUM_BITS-1:0];
        count_now = count_now + 1'b1;
        n = (bs_now == '0) ? rlm_pkg::BS_BITS'(1) : bs_now;
        if (count_now >= n) begin
            q = {sum_now, {rlm_pkg::FRAC_BITS{1'b0}}} / rlm_pkg::Q_BITS'(n);
            if (q < (rlm_pkg::Q_BITS'(1) << rlm_pkg::FRAC_BITS)) begin
                r.below = 1'b1;
                r.level = '0;
            end else begin
                r.below = 1'b0;
                r.level = db_level(q);
            end
            level_queue.push_back(r);
            sum_now = '0;
            count_now = '0;
        end
    endfunction

    // Sample around the offset with the current amplitude, plus some outliers
    function automatic logic [rlm_pkg::S_TDATA_BITS-1:0] pick_sample();
        int                               v;
        int                               span;
        logic [rlm_pkg::S_TDATA_BITS-1:0] word;
        span = 1 << amp_bits;
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, SAMPLE_MAX));
            1: v = int'(dc_now);
            2: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            default: begin
                v = int'(dc_now) + int'($urandom_range(0, span)) - int'($urandom_range(0, span));
                if (v < 0) v = 0;
                else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            end
        endcase
        word = '0;
        word[rlm_pkg::SAMPLE_BITS-1:0] = v[rlm_pkg::SAMPLE_BITS-1:0];
        // pad bits above the sample must be ignored
        if ($urandom_range(0, 7) == 0) begin
            word[rlm_pkg::S_TDATA_BITS-1:rlm_pkg::SAMPLE_BITS] =
                (rlm_pkg::S_TDATA_BITS - rlm_pkg::SAMPLE_BITS)'($urandom);
        end
        return word;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [rlm_pkg::M_TDATA_BITS-1:0] data,
                                input logic user);
        level_t got;
        level_t want;
        got.level = data[rlm_pkg::LEVEL_BITS-1:0];
        got.below = user;
        if (level_queue.size() == 0) begin
            report_mismatch("unexpected transfer, level_db", int'(got.level), 0);
            return;
        end
        want = level_queue.pop_front();
        if (data !== rlm_pkg::M_TDATA_BITS'(want.level)) begin
            report_mismatch("level_db", int'(data), int'(want.level));
        end
        if (got.below !== want.below) begin
            report_mismatch("below_floor", int'(got.below), int'(want.below));
        end
    endtask

    // Result side: check each transfer, then stall for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tuser);
                hold_left = rx_steady ? 0 : int'($urandom_range(0, 19));
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One sample transfer; valid stays high when the next gap is zero
    task automatic send_sample(input logic [rlm_pkg::S_TDATA_BITS-1:0] data);
        int gap;
        gap = tx_steady ? 0 : int'($urandom_range(0, 19));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        accumulate_sample(data);
    endtask

    // Stop sending and wait for every queued level; optionally let the block settle
    task automatic drain_results(input bit settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (level_queue.size() != 0);
        if (settle) repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rlm_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [rlm_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == rlm_pkg::REG_BLOCK_SIZE) bs_now = value[rlm_pkg::BS_BITS-1:0];
        else dc_now = value[rlm_pkg::DC_BITS-1:0];
        @(posedge aclk);
    endtask

    // Reset register values: two blocks of 100 samples
    task automatic test_default_config();
        for (int b = 0; b < 2; b++) begin
            amp_bits = $urandom_range(4, 11);
            for (int i = 0; i < int'(rlm_pkg::BLOCK_SIZE_RST); i++) send_sample(pick_sample());
        end
        drain_results(1'b1);
    endtask

    task automatic test_directed_cases();
        // single-sample blocks: silence, smallest nonzero mean, both rails, pad bits
        write_reg(rlm_pkg::REG_BLOCK_SIZE, rlm_pkg::CFG_DATA_BITS'(1));
        write_reg(rlm_pkg::REG_DC_OFFSET, rlm_pkg::CFG_DATA_BITS'(2048));
        send_sample(rlm_pkg::S_TDATA_BITS'(2048));
        send_sample(rlm_pkg::S_TDATA_BITS'(2049));
        send_sample(rlm_pkg::S_TDATA_BITS'(2047));
        send_sample(rlm_pkg::S_TDATA_BITS'(0));
        send_sample(rlm_pkg::S_TDATA_BITS'(SAMPLE_MAX));
        send_sample({{(rlm_pkg::S_TDATA_BITS - rlm_pkg::SAMPLE_BITS){1'b1}},
                     rlm_pkg::SAMPLE_BITS'(2048)});
        drain_results(1'b1);

        // zero block size behaves as one
        write_reg(rlm_pkg::REG_BLOCK_SIZE, rlm_pkg::CFG_DATA_BITS'(0));
        send_sample(rlm_pkg::S_TDATA_BITS'(2051));
        send_sample(rlm_pkg::S_TDATA_BITS'(1000));
        drain_results(1'b1);

        // offset extremes
        write_reg(rlm_pkg::REG_DC_OFFSET, rlm_pkg::CFG_DATA_BITS'(0));
        send_sample(rlm_pkg::S_TDATA_BITS'(SAMPLE_MAX));
        send_sample(rlm_pkg::S_TDATA_BITS'(0));
        drain_results(1'b1);
        write_reg(rlm_pkg::REG_DC_OFFSET, rlm_pkg::CFG_DATA_BITS'(SAMPLE_MAX));
        send_sample(rlm_pkg::S_TDATA_BITS'(0));
        send_sample(rlm_pkg::S_TDATA_BITS'(SAMPLE_MAX));
        drain_results(1'b1);

        // block size lowered below the running count: next sample closes the block
        write_reg(rlm_pkg::REG_BLOCK_SIZE, rlm_pkg::CFG_DATA_BITS'(8));
        write_reg(rlm_pkg::REG_DC_OFFSET, rlm_pkg::CFG_DATA_BITS'(2048));
        for (int i = 0; i < 5; i++) send_sample(rlm_pkg::S_TDATA_BITS'(2048 + 100 * i));
        drain_results(1'b1);
        write_reg(rlm_pkg::REG_BLOCK_SIZE, rlm_pkg::CFG_DATA_BITS'(3));
        send_sample(rlm_pkg::S_TDATA_BITS'(1500));
        drain_results(1'b1);

        // offset change mid-block keeps the partial sum
        write_reg(rlm_pkg::REG_BLOCK_SIZE, rlm_pkg::CFG_DATA_BITS'(4));
        send_sample(rlm_pkg::S_TDATA_BITS'(3000));
        send_sample(rlm_pkg::S_TDATA_BITS'(1200));
        drain_results(1'b1);
        write_reg(rlm_pkg::REG_DC_OFFSET, rlm_pkg::CFG_DATA_BITS'(1000));
        send_sample(rlm_pkg::S_TDATA_BITS'(1010));
        send_sample(rlm_pkg::S_TDATA_BITS'(400));
        drain_results(1'b1);
    endtask

    // Largest block at full swing: the loudest level the meter can report
    task automatic test_full_scale_block();
        write_reg(rlm_pkg::REG_BLOCK_SIZE, rlm_pkg::CFG_DATA_BITS'(255));
        write_reg(rlm_pkg::REG_DC_OFFSET, rlm_pkg::CFG_DATA_BITS'(0));
        tx_steady = 1'b1;
        for (int i = 0; i < 255; i++) send_sample(rlm_pkg::S_TDATA_BITS'(SAMPLE_MAX));
        tx_steady = 1'b0;
        drain_results(1'b1);
    endtask

    // Random phases, mostly short blocks so results come often
    task automatic test_random_blocks();
        int                                sent;
        int                                phase;
        int                                n_items;
        int                                pick;
        logic [rlm_pkg::CFG_DATA_BITS-1:0] bs_val;
        logic [rlm_pkg::CFG_DATA_BITS-1:0] dc_val;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) bs_val = '0;
            else if (pick == 1) bs_val = rlm_pkg::CFG_DATA_BITS'($urandom_range(13, 64));
            else bs_val = rlm_pkg::CFG_DATA_BITS'($urandom_range(1, 12));
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                dc_val = rlm_pkg::CFG_DATA_BITS'($urandom_range(0, SAMPLE_MAX));
            end else if (pick == 1) begin
                dc_val = $urandom_range(0, 1) ? rlm_pkg::CFG_DATA_BITS'(SAMPLE_MAX) : '0;
            end else begin
                dc_val = rlm_pkg::CFG_DATA_BITS'(2048);
            end

            // change one or both registers; the partial block carries over
            pick = $urandom_range(0, 2);
            if (pick != 1) write_reg(rlm_pkg::REG_BLOCK_SIZE, bs_val);
            if (pick != 0) write_reg(rlm_pkg::REG_DC_OFFSET, dc_val);

            amp_bits  = $urandom_range(0, 11);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            n_items   = $urandom_range(20, 50);
            for (int i = 0; i < n_items; i++) begin
                send_sample(pick_sample());
                // sender holds off until the meter has delivered everything
                if (phase % 2 == 0 && i == n_items / 2) drain_results(1'b0);
            end
            sent += n_items;
            phase++;
            drain_results(1'b1);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_config();
        test_directed_cases();
        test_full_scale_block();
        test_random_blocks();

        drain_results(1'b1);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
